FILE: rtl/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

  localparam int unsigned SampleW = 16;

  typedef logic [SampleW-1:0] sample_t;

  localparam logic RegFilterEnable = 1'b0;

  // what one cell shows its neighbors
  typedef struct packed {
    sample_t val;
    logic    lt;          // value below the incoming sample
    logic    before_old;  // sits ahead of the entry that leaves
  } swm_nbr_t;

  // broadcast to every cell
  typedef struct packed {
    logic    prime;
    logic    load;
    sample_t smp;
    sample_t oldest_val;
  } swm_ctl_t;

endpackage

FILE: rtl/swm_cell.sv
`timescale 1ns / 1ps

module swm_cell #(
  parameter int unsigned WINDOW = 16,
  parameter int unsigned IDX    = 0,
  parameter int unsigned AW     = 4
) (
  input  logic                clk_i,
  input  swm_pkg::swm_ctl_t   ctl_i,
  input  swm_pkg::swm_nbr_t   left_i,
  input  logic [AW-1:0]       left_age_i,
  input  swm_pkg::swm_nbr_t   right_i,
  input  logic [AW-1:0]       right_age_i,
  output swm_pkg::swm_nbr_t   self_o,
  output logic [AW-1:0]       age_o,
  output swm_pkg::sample_t    val_next_o
);
  import swm_pkg::*;

  localparam logic [AW-1:0] AgeOld  = AW'(WINDOW - 1);
  localparam logic [AW-1:0] AgeInit = AW'(IDX);

  sample_t       val_q, val_d;
  logic [AW-1:0] age_q, age_d;
  logic          lt, before_old, rlt_self, rlt_left;

  assign lt         = val_q < ctl_i.smp;
  // entries sort by value, then by age, so the oldest is last among equals
  assign before_old = !(val_q > ctl_i.oldest_val) && (age_q != AgeOld);

  assign rlt_self = before_old ? lt : right_i.lt;
  assign rlt_left = left_i.before_old ? left_i.lt : lt;

  always_comb begin
    val_d = val_q;
    age_d = age_q;
    if (ctl_i.prime) begin
      val_d = ctl_i.smp;
      age_d = AgeInit;
    end else if (ctl_i.load) begin
      if (rlt_self) begin
        val_d = before_old ? val_q : right_i.val;
        age_d = (before_old ? age_q : right_age_i) + AW'(1);
      end else if (rlt_left) begin
        val_d = ctl_i.smp;
        age_d = '0;
      end else begin
        val_d = left_i.before_old ? left_i.val : val_q;
        age_d = (left_i.before_old ? left_age_i : age_q) + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    age_q <= age_d;
  end

  assign self_o     = '{val: val_q, lt: lt, before_old: before_old};
  assign age_o      = age_q;
  assign val_next_o = val_d;

endmodule

FILE: rtl/sliding_window_median_filter.sv
`timescale 1ns / 1ps
// output: the median of a word is registered when the word is taken and shows on the output in the cycle after
// throughput: one word per cycle while the output is not stalled; the sorted row of cells removes the oldest
// entry and inserts the new sample in a single update
// reset: primed flag and output valid clear, filter_enable returns to 1; window contents stay
// undefined until the first nonzero sample taken while enabled fills the row
module sliding_window_median_filter #(
  parameter int unsigned WINDOW = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  swm_pkg::sample_t      sample_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output swm_pkg::sample_t      median_o
);
  import swm_pkg::*;

  localparam int unsigned   AW     = (WINDOW > 2) ? $clog2(WINDOW) : 1;
  localparam logic [AW-1:0] AgeNxt = AW'(WINDOW - 2);
  localparam int unsigned   Mid    = WINDOW / 2;

  logic     enable_q;
  logic     primed_q;
  logic     out_valid_q;
  sample_t  median_q, median_d;
  sample_t  oldest_q, oldest_d;
  logic     accept, active;
  swm_ctl_t ctl;

  swm_nbr_t         nbr [WINDOW+2];
  logic [AW-1:0]    age [WINDOW+2];
  sample_t          val_next [WINDOW];

  // apb: one register, index taken from paddr[2]
  assign pready = 1'b1;
  assign prdata = {31'b0, enable_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (psel && penable && pwrite && (paddr[2] == RegFilterEnable)) begin
      enable_q <= pwdata[0];
    end
  end

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign active      = enable_q && (sample_i != '0);
  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

  assign ctl = '{prime: accept && active && !primed_q,
                 load: accept && active && primed_q,
                 smp: sample_i,
                 oldest_val: oldest_q};

  // boundary cells: everything sorts after the left edge, nothing after the right
  assign nbr[0]        = '{val: '0, lt: 1'b1, before_old: 1'b1};
  assign age[0]        = '0;
  assign nbr[WINDOW+1] = '{val: '0, lt: 1'b0, before_old: 1'b0};
  assign age[WINDOW+1] = '0;

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    swm_cell #(
      .WINDOW(WINDOW),
      .IDX   (g),
      .AW    (AW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .left_i     (nbr[g]),
      .left_age_i (age[g]),
      .right_i    (nbr[g+2]),
      .right_age_i(age[g+2]),
      .self_o     (nbr[g+1]),
      .age_o      (age[g+1]),
      .val_next_o (val_next[g])
    );
  end

  // next oldest entry is the one one step younger than the current oldest
  always_comb begin
    oldest_d = '0;
    for (int i = 0; i < WINDOW; i++) begin
      oldest_d = oldest_d | ((age[i+1] == AgeNxt) ? nbr[i+1].val : '0);
    end
  end

  always_comb begin
    if (!active) begin
      median_d = '0;
    end else if (!primed_q) begin
      median_d = sample_i;
    end else begin
      median_d = val_next[Mid];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        primed_q    <= active;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      median_q <= median_d;
    end
    if (ctl.prime) begin
      oldest_q <= sample_i;
    end else if (ctl.load) begin
      oldest_q <= oldest_d;
    end
  end

endmodule
